@@ rtl/pdr_pkg.sv @@
// shared types, constants and the arctangent table for the polar dead-reckoning tracker
// used by pdr_ctrl, pdr_datapath and polar_dead_reckoning_tracker
package pdr_pkg;

  localparam int HIST_DEPTH = 4;
  localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
  localparam int CNT_W      = 3;

  localparam int POS_W  = 26;
  localparam int ANG_W  = 15;
  localparam int MAG_W  = 24;
  localparam int DEG_W  = 16;

  // cordic datapath widths
  localparam int CW         = 33;
  localparam int AW         = 30;
  localparam int FINE_SHIFT = 12;
  localparam int PROD_W     = CW + MAG_W + 1;
  localparam int RND_SHIFT  = 30;
  localparam int RND_W      = PROD_W - RND_SHIFT + 1;
  localparam int SUM_W      = RND_W + 1;
  localparam int SQ_W       = 2 * POS_W;
  localparam int REM_W      = POS_W + 3;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = POS_W;
  localparam int STEP_W       = 5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 152;

  localparam logic [ANG_W-1:0] FULL_TURN  = 15'd23040;
  localparam logic [ANG_W-1:0] QUARTER    = 15'd5760;
  localparam logic [ANG_W-1:0] THREE_QTR  = 15'd17280;
  localparam logic [ANG_W-1:0] HALF_TURN  = 15'd11520;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [AW-1:0] HALF_FINE   = 30'sd47185920;
  localparam logic signed [AW-1:0] FULL_FINE   = 30'sd94371840;

  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(33554431);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(33554432);

  localparam logic OP_START = 1'b0;
  localparam logic OP_MOVE  = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_INIT, CMD_ROT, CMD_MULX, CMD_MULY, CMD_RNDY, CMD_ADD,
    CMD_SQX, CMD_SQY, CMD_SQSUM, CMD_SQRT, CMD_VINIT, CMD_VEC, CMD_BRG, CMD_FIN
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_ROT, ST_MULX, ST_MULY, ST_RNDY, ST_ADD, ST_SQX, ST_SQY,
    ST_SQSUM, ST_SQRT, ST_VINIT, ST_VEC, ST_BRG, ST_FIN
  } pdr_state_e;

  typedef struct packed {
    dp_cmd_e           cmd;
    logic [STEP_W-1:0] step;
  } dp_ctrl_t;

  typedef struct packed {
    logic is_move;
  } dp_stat_t;

  // atan(2^-i) in 2^-18 degree
  function automatic logic [23:0] atan_fine(input logic [STEP_W-1:0] i);
    logic [23:0] v;
    unique case (i)
      5'd0:  v = 24'd11796480;
      5'd1:  v = 24'd6963869;
      5'd2:  v = 24'd3679517;
      5'd3:  v = 24'd1867780;
      5'd4:  v = 24'd937515;
      5'd5:  v = 24'd469214;
      5'd6:  v = 24'd234664;
      5'd7:  v = 24'd117339;
      5'd8:  v = 24'd58671;
      5'd9:  v = 24'd29335;
      5'd10: v = 24'd14668;
      5'd11: v = 24'd7334;
      5'd12: v = 24'd3667;
      5'd13: v = 24'd1833;
      5'd14: v = 24'd917;
      5'd15: v = 24'd458;
      5'd16: v = 24'd229;
      5'd17: v = 24'd115;
      5'd18: v = 24'd57;
      5'd19: v = 24'd29;
      5'd20: v = 24'd14;
      5'd21: v = 24'd7;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pdr_ctrl.sv @@
// sequencer for the tracker: steps the datapath through cordic, multiply, sqrt and output
// depends on pdr_pkg
module pdr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pdr_pkg::dp_stat_t stat_i,
  output pdr_pkg::dp_ctrl_t ctrl_o
);
  import pdr_pkg::*;

  pdr_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              valid_q, valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.step = step_q;
    in_ready_o  = 1'b0;
    valid_d     = valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = CMD_LOAD;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        ctrl_o.cmd = CMD_INIT;
        step_d     = '0;
        state_d    = ST_ROT;
      end
      ST_ROT: begin
        ctrl_o.cmd = CMD_ROT;
        step_d     = step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_MULX;
      end
      ST_MULX: begin
        ctrl_o.cmd = CMD_MULX;
        state_d    = ST_MULY;
      end
      ST_MULY: begin
        ctrl_o.cmd = CMD_MULY;
        state_d    = ST_RNDY;
      end
      ST_RNDY: begin
        ctrl_o.cmd = CMD_RNDY;
        state_d    = ST_ADD;
      end
      ST_ADD: begin
        ctrl_o.cmd = CMD_ADD;
        state_d    = stat_i.is_move ? ST_SQX : ST_FIN;
      end
      ST_SQX: begin
        ctrl_o.cmd = CMD_SQX;
        state_d    = ST_SQY;
      end
      ST_SQY: begin
        ctrl_o.cmd = CMD_SQY;
        state_d    = ST_SQSUM;
      end
      ST_SQSUM: begin
        ctrl_o.cmd = CMD_SQSUM;
        step_d     = '0;
        state_d    = ST_SQRT;
      end
      ST_SQRT: begin
        ctrl_o.cmd = CMD_SQRT;
        step_d     = step_q + 1'b1;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) state_d = ST_VINIT;
      end
      ST_VINIT: begin
        ctrl_o.cmd = CMD_VINIT;
        step_d     = '0;
        state_d    = ST_VEC;
      end
      ST_VEC: begin
        ctrl_o.cmd = CMD_VEC;
        step_d     = step_q + 1'b1;
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_BRG;
      end
      ST_BRG: begin
        ctrl_o.cmd = CMD_BRG;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // wait until the output register is free
        if (!valid_q || out_ready_i) begin
          ctrl_o.cmd = CMD_FIN;
          valid_d    = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = valid_q;

endmodule

@@ rtl/pdr_datapath.sv @@
// datapath of the tracker: shared cordic, multiplier, sqrt, position and history registers
// depends on pdr_pkg
module pdr_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pdr_pkg::dp_ctrl_t         ctrl_i,
  output pdr_pkg::dp_stat_t         stat_o,
  input  logic                      op_i,
  input  logic [pdr_pkg::ANG_W-1:0] course_i,
  input  logic [pdr_pkg::ANG_W-1:0] bearing_i,
  input  logic [pdr_pkg::MAG_W-1:0] magnitude_i,
  output logic [pdr_pkg::POS_W-1:0] pos_x_o,
  output logic [pdr_pkg::POS_W-1:0] pos_y_o,
  output logic [pdr_pkg::POS_W-1:0] range_o,
  output logic [pdr_pkg::ANG_W-1:0] bearing_o,
  output logic [pdr_pkg::CNT_W-1:0] count_o,
  output logic [pdr_pkg::POS_W-1:0] oldest_x_o,
  output logic [pdr_pkg::POS_W-1:0] oldest_y_o
);
  import pdr_pkg::*;

  // latched item
  logic             op_q;
  logic [ANG_W-1:0] course_q, brg_q, brg_red_q;
  logic [MAG_W-1:0] mag_q;

  // cordic
  logic signed [CW-1:0] x_q, y_q;
  logic signed [AW-1:0] acc_q;
  logic                 neg_q;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [RND_W-1:0]  dx_q, dy_q;
  logic signed [POS_W-1:0]  cur_x_q, cur_y_q;

  logic [SQ_W-1:0]  sq_a_q, sq_b_q, n_q;
  logic [REM_W-1:0] rem_q;
  logic [POS_W-1:0] root_q, range_q;
  logic             zero_q;
  logic [ANG_W-1:0] brg_fine_q;

  logic signed [POS_W-1:0] trail_x_q [HIST_DEPTH];
  logic signed [POS_W-1:0] trail_y_q [HIST_DEPTH];
  logic [FILL_W-1:0]       fill_q;

  logic [POS_W-1:0] out_x_q, out_y_q, out_rng_q, out_ox_q, out_oy_q;
  logic [ANG_W-1:0] out_brg_q;
  logic [CNT_W-1:0] out_cnt_q;

  // angle reduction and quadrant fold
  logic [ANG_W-1:0]        ang_sel, ang_red, brg_red;
  logic signed [DEG_W-1:0] deg;
  logic                    fold_neg;
  logic signed [AW-1:0]    z_init;

  always_comb begin
    ang_sel  = op_q ? course_q : brg_q;
    ang_red  = (ang_sel >= FULL_TURN) ? ang_sel - FULL_TURN : ang_sel;
    brg_red  = (brg_q >= FULL_TURN) ? brg_q - FULL_TURN : brg_q;
    fold_neg = 1'b0;
    if (ang_red > QUARTER && ang_red < THREE_QTR) begin
      deg      = $signed({1'b0, ang_red}) - $signed({1'b0, HALF_TURN});
      fold_neg = 1'b1;
    end else if (ang_red >= THREE_QTR) begin
      deg = $signed({1'b0, ang_red}) - $signed({1'b0, FULL_TURN});
    end else begin
      deg = $signed({1'b0, ang_red});
    end
    z_init = {{(AW - DEG_W){deg[DEG_W-1]}}, deg} <<< FINE_SHIFT;
  end

  // one cordic micro-rotation, shared by rotation and vectoring
  logic                 vec_mode, pos_dir;
  logic signed [CW-1:0] x_sh, y_sh, x_nx, y_nx;
  logic signed [AW-1:0] at, acc_nx;

  always_comb begin
    vec_mode = (ctrl_i.cmd == CMD_VEC);
    pos_dir  = vec_mode ? y_q[CW-1] : ~acc_q[AW-1];
    x_sh     = x_q >>> ctrl_i.step;
    y_sh     = y_q >>> ctrl_i.step;
    at       = $signed({{(AW - 24){1'b0}}, atan_fine(ctrl_i.step)});
    if (pos_dir) begin
      x_nx   = x_q - y_sh;
      y_nx   = y_q + x_sh;
      acc_nx = acc_q - at;
    end else begin
      x_nx   = x_q + y_sh;
      y_nx   = y_q - x_sh;
      acc_nx = acc_q + at;
    end
  end

  // multiplier operand and rounding of the product, half away from zero
  logic signed [MAG_W:0]    mul_a;
  logic signed [CW-1:0]     mul_b_x, mul_b_y;
  logic [PROD_W-1:0]        p_abs, p_rnd;
  logic signed [RND_W-1:0]  rnd;

  always_comb begin
    mul_a   = $signed({1'b0, mag_q});
    mul_b_x = neg_q ? -x_q : x_q;
    mul_b_y = neg_q ? -y_q : y_q;
    p_abs   = prod_q[PROD_W-1] ? $unsigned(-prod_q) : $unsigned(prod_q);
    p_rnd   = (p_abs + (PROD_W'(1) << (RND_SHIFT - 1))) >> RND_SHIFT;
    rnd     = prod_q[PROD_W-1] ? -$signed(p_rnd[RND_W-1:0]) : $signed(p_rnd[RND_W-1:0]);
  end

  // position update with saturation
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [POS_W-1:0] new_x, new_y;

  always_comb begin
    sum_x = $signed({{(SUM_W - RND_W){dx_q[RND_W-1]}}, dx_q});
    sum_y = $signed({{(SUM_W - RND_W){dy_q[RND_W-1]}}, dy_q});
    if (op_q) begin
      sum_x = sum_x + $signed({{(SUM_W - POS_W){cur_x_q[POS_W-1]}}, cur_x_q});
      sum_y = sum_y + $signed({{(SUM_W - POS_W){cur_y_q[POS_W-1]}}, cur_y_q});
    end
    if (sum_x > POS_MAX) new_x = POS_MAX[POS_W-1:0];
    else if (sum_x < POS_MIN) new_x = POS_MIN[POS_W-1:0];
    else new_x = sum_x[POS_W-1:0];
    if (sum_y > POS_MAX) new_y = POS_MAX[POS_W-1:0];
    else if (sum_y < POS_MIN) new_y = POS_MIN[POS_W-1:0];
    else new_y = sum_y[POS_W-1:0];
  end

  // full-width squares of the position
  logic signed [SQ_W-1:0] sq_x, sq_y;

  always_comb begin
    sq_x = cur_x_q * cur_x_q;
    sq_y = cur_y_q * cur_y_q;
  end

  // restoring square root, two radicand bits a step
  logic [REM_W-1:0] rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], n_q[SQ_W-1:SQ_W-2]};
    trial  = {1'b0, root_q, 2'b01};
  end

  // bearing wrap and rounding
  logic signed [AW-1:0] acc_wrap, acc_rnd;
  logic [ANG_W-1:0]     brg_mod;

  always_comb begin
    acc_wrap = acc_q[AW-1] ? acc_q + FULL_FINE : acc_q;
    acc_rnd  = (acc_wrap + AW'(1 << (FINE_SHIFT - 1))) >>> FINE_SHIFT;
    brg_mod  = (brg_fine_q >= FULL_TURN) ? brg_fine_q - FULL_TURN : brg_fine_q;
  end

  // history push
  logic signed [POS_W-1:0] trail_x_d [HIST_DEPTH];
  logic signed [POS_W-1:0] trail_y_d [HIST_DEPTH];
  logic [FILL_W-1:0]       fill_d;

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      trail_x_d[i] = trail_x_q[i];
      trail_y_d[i] = trail_y_q[i];
    end
    fill_d = fill_q;
    if (!op_q) begin
      trail_x_d[0] = cur_x_q;
      trail_y_d[0] = cur_y_q;
      fill_d       = FILL_W'(1);
    end else if (fill_q < FILL_W'(HIST_DEPTH)) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        if (fill_q == FILL_W'(i)) begin
          trail_x_d[i] = cur_x_q;
          trail_y_d[i] = cur_y_q;
        end
      end
      fill_d = fill_q + 1'b1;
    end else begin
      for (int i = 0; i < HIST_DEPTH - 1; i++) begin
        trail_x_d[i] = trail_x_q[i + 1];
        trail_y_d[i] = trail_y_q[i + 1];
      end
      trail_x_d[HIST_DEPTH-1] = cur_x_q;
      trail_y_d[HIST_DEPTH-1] = cur_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      fill_q  <= '0;
    end else begin
      if (ctrl_i.cmd == CMD_ADD) begin
        cur_x_q <= new_x;
        cur_y_q <= new_y;
      end
      if (ctrl_i.cmd == CMD_FIN) fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_LOAD: begin
        op_q     <= op_i;
        course_q <= course_i;
        brg_q    <= bearing_i;
        mag_q    <= magnitude_i;
      end
      CMD_INIT: begin
        x_q       <= CORDIC_GAIN;
        y_q       <= '0;
        acc_q     <= z_init;
        neg_q     <= fold_neg;
        brg_red_q <= brg_red;
      end
      CMD_ROT, CMD_VEC: begin
        x_q   <= x_nx;
        y_q   <= y_nx;
        acc_q <= acc_nx;
      end
      CMD_MULX: prod_q <= mul_a * mul_b_x;
      CMD_MULY: begin
        dx_q   <= rnd;
        prod_q <= mul_a * mul_b_y;
      end
      CMD_RNDY: dy_q <= rnd;
      CMD_SQX:  sq_a_q <= $unsigned(sq_x);
      CMD_SQY:  sq_b_q <= $unsigned(sq_y);
      CMD_SQSUM: begin
        n_q    <= sq_a_q + sq_b_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      CMD_SQRT: begin
        n_q <= n_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[POS_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[POS_W-2:0], 1'b0};
        end
      end
      CMD_VINIT: begin
        range_q <= root_q + POS_W'(rem_q > {{(REM_W - POS_W){1'b0}}, root_q});
        zero_q  <= (cur_x_q == '0) && (cur_y_q == '0);
        // turn the vector by half a turn when it points left
        if (cur_x_q[POS_W-1]) begin
          x_q   <= -({{(CW - POS_W){cur_x_q[POS_W-1]}}, cur_x_q} <<< 4);
          y_q   <= -({{(CW - POS_W){cur_y_q[POS_W-1]}}, cur_y_q} <<< 4);
          acc_q <= HALF_FINE;
        end else begin
          x_q   <= {{(CW - POS_W){cur_x_q[POS_W-1]}}, cur_x_q} <<< 4;
          y_q   <= {{(CW - POS_W){cur_y_q[POS_W-1]}}, cur_y_q} <<< 4;
          acc_q <= '0;
        end
      end
      CMD_BRG: brg_fine_q <= acc_rnd[ANG_W-1:0];
      CMD_FIN: begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
          trail_x_q[i] <= trail_x_d[i];
          trail_y_q[i] <= trail_y_d[i];
        end
        out_x_q   <= cur_x_q;
        out_y_q   <= cur_y_q;
        out_cnt_q <= CNT_W'(fill_d);
        out_ox_q  <= trail_x_d[0];
        out_oy_q  <= trail_y_d[0];
        if (op_q) begin
          out_rng_q <= range_q;
          out_brg_q <= zero_q ? '0 : brg_mod;
        end else begin
          out_rng_q <= {{(POS_W - MAG_W){1'b0}}, mag_q};
          out_brg_q <= brg_red_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o.is_move = (op_q == OP_MOVE);

  assign pos_x_o    = out_x_q;
  assign pos_y_o    = out_y_q;
  assign range_o    = out_rng_q;
  assign bearing_o  = out_brg_q;
  assign count_o    = out_cnt_q;
  assign oldest_x_o = out_ox_q;
  assign oldest_y_o = out_oy_q;

endmodule

@@ rtl/polar_dead_reckoning_tracker.sv @@
// top level of the polar dead-reckoning tracker: stream ports, sequencer and datapath
// depends on pdr_pkg, pdr_ctrl and pdr_datapath
//
//   channel   direction  beat contents
//   s_axis    in         tuser: op; tdata: course, bearing_in, magnitude
//   m_axis    out        tdata: pos_x, pos_y, range_out, bearing_out, history_count,
//                               oldest_x, oldest_y
//
// a start beat runs one 24-step cordic pass; a move beat runs two 24-step cordic passes on
// one shared shift-add unit and a 26-step square root
// one beat is in work at a time; a new beat is taken while the last result waits on m_axis
// rst_ni clears position, history fill and the handshake state; no clearing pass is needed
// a stalled result holds the output register and parks the sequencer before its write
module polar_dead_reckoning_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // course [14:0], bearing_in [29:15], magnitude [53:30], zero fill
  input  logic [pdr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op [0]
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // pos_x [25:0], pos_y [51:26], range_out [77:52], bearing_out [92:78],
  // history_count [95:93], oldest_x [121:96], oldest_y [147:122], zero fill
  output logic [pdr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import pdr_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  logic [POS_W-1:0] pos_x, pos_y, range_out, oldest_x, oldest_y;
  logic [ANG_W-1:0] bearing_out;
  logic [CNT_W-1:0] history_count;

  pdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  pdr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .op_i        (s_axis_tuser_i),
    .course_i    (s_axis_tdata_i[14:0]),
    .bearing_i   (s_axis_tdata_i[29:15]),
    .magnitude_i (s_axis_tdata_i[53:30]),
    .pos_x_o     (pos_x),
    .pos_y_o     (pos_y),
    .range_o     (range_out),
    .bearing_o   (bearing_out),
    .count_o     (history_count),
    .oldest_x_o  (oldest_x),
    .oldest_y_o  (oldest_y)
  );

  assign m_axis_tdata_o = {4'b0, oldest_y, oldest_x, history_count, bearing_out,
                           range_out, pos_y, pos_x};

endmodule
